[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AST_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define AST_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/esu_pkg.sv]
// Shared types and status codes of the escaped string unescaper.
package esu_pkg;

	typedef enum logic [2:0] {
		ST_BUSY    = 3'd0,
		ST_DONE    = 3'd1,
		ST_NOMEM   = 3'd2,
		ST_FAULT   = 3'd3,
		ST_NOTIMPL = 3'd4
	} status_t;

	// One command per input byte: up to four result items.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            bvalid;
		status_t         status;
	} cmd_t;

endpackage

[hdl/escaped_string_unescaper.sv]
// Top level of the escaped string unescaper.
// Input channel: in_valid/in_ready with in_byte, one string byte per transfer;
//   a zero byte terminates the string. Output channel: out_valid/out_ready with
//   out_byte, byte_valid, status and run_last, one result per transfer.
// Each input byte yields 1 to 4 results; run_last marks the final one.
// Each result passes through the command queue and then the output register.
// Throughput: one input byte per cycle while the queue is not full and each
//   byte yields one result; a completed \u escape sends its UTF-8 bytes as
//   separate results, and the command queue absorbs the front end meanwhile.
// cfg_we/cfg_data write output_capacity; the new value is loaded into the
//   space counter at the next accepted terminator.
// Reset (arst_n low) clears the parser, the queue and the output valid flag;
//   capacity and space counter return to 65535. No clearing pass is needed.
// When the receiver stalls, the output register holds its result, the queue
//   fills, and in_ready drops once QUEUE_DEPTH commands are waiting.
module escaped_string_unescaper #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic [2:0]  status,
	output logic        run_last
);
	import esu_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	// parser: one command per accepted byte
	esu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// decouples the parser from output stalls
	esu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (push_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (head_cmd),
		.empty  (q_empty)
	);

	// serializer: one result transfer per cycle while the receiver is ready
	esu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_cmd),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.status     (status),
		.run_last   (run_last)
	);

endmodule

[hdl/esu_front.sv]
// Front end: escape parser, UTF-8 encoder, space count; one byte/cycle unless full.
module esu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            q_full,
	output logic            q_push,
	output esu_pkg::cmd_t   q_cmd
);
	import esu_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ESC     = 3'd1,
		PH_XHEX    = 3'd2,
		PH_UHEX    = 3'd3,
		PH_PAIR_BS = 3'd4,
		PH_PAIR_U  = 3'd5,
		PH_LHEX    = 3'd6
	} phase_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_X     = 8'h78;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
		else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
		return v;
	endfunction

	phase_t      phase_q, phase_d;
	logic [15:0] hex_q, hex_d;
	logic        bad_q, bad_d;
	logic [1:0]  dcnt_q, dcnt_d;
	logic [9:0]  hs_q, hs_d;
	logic [15:0] space_q, space_d;
	status_t     err_q, err_d;
	logic [15:0] cap_q;

	logic [4:0]      dig;
	logic [15:0]     u_acc;
	logic            u_bad;
	logic [15:0]     u_code;
	logic [20:0]     cp;
	logic [2:0]      enc_len;
	logic [3:0][7:0] enc_bytes;
	logic            fail_en;
	status_t         fail_code;
	cmd_t            cmd;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;
	assign q_cmd    = cmd;

	// digit datapath shared by the \u and \x phases
	always_comb begin
		dig    = hex_val(in_byte);
		u_bad  = bad_q | dig[4];
		u_acc  = dig[4] ? hex_q : {hex_q[11:0], dig[3:0]};
		u_code = u_bad ? 16'h0000 : u_acc;
		if (phase_q == PH_LHEX) cp = 21'h10000 + {1'b0, hs_q, u_code[9:0]};
		else cp = {5'b0, u_code};
	end

	// UTF-8 encoder
	always_comb begin
		enc_bytes = '0;
		if (cp < 21'h80) begin
			enc_len      = 3'd1;
			enc_bytes[0] = {1'b0, cp[6:0]};
		end else if (cp < 21'h800) begin
			enc_len      = 3'd2;
			enc_bytes[0] = {3'b110, cp[10:6]};
			enc_bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			enc_len      = 3'd3;
			enc_bytes[0] = {4'b1110, cp[15:12]};
			enc_bytes[1] = {2'b10, cp[11:6]};
			enc_bytes[2] = {2'b10, cp[5:0]};
		end else begin
			enc_len      = 3'd4;
			enc_bytes[0] = {5'b11110, cp[20:18]};
			enc_bytes[1] = {2'b10, cp[17:12]};
			enc_bytes[2] = {2'b10, cp[11:6]};
			enc_bytes[3] = {2'b10, cp[5:0]};
		end
	end

	always_comb begin
		phase_d   = phase_q;
		hex_d     = hex_q;
		bad_d     = bad_q;
		dcnt_d    = dcnt_q;
		hs_d      = hs_q;
		space_d   = space_q;
		err_d     = err_q;
		fail_en   = 1'b0;
		fail_code = ST_FAULT;
		cmd       = '0;
		cmd.status = ST_BUSY;

		if (in_byte == CH_NUL) begin
			if (err_q != ST_BUSY) begin
				cmd.status = err_q;
			end else if (phase_q != PH_IDLE) begin
				cmd.status = ST_FAULT;
			end else begin
				cmd.bvalid = 1'b1;
				cmd.status = ST_DONE;
			end
			phase_d = PH_IDLE;
			hex_d   = '0;
			bad_d   = 1'b0;
			dcnt_d  = '0;
			hs_d    = '0;
			space_d = cap_q;
			err_d   = ST_BUSY;
		end else if (err_q != ST_BUSY) begin
			cmd.status = err_q;
		end else begin
			unique case (phase_q) inside
				PH_IDLE: begin
					if (space_q == 16'd0) begin
						fail_en   = 1'b1;
						fail_code = ST_NOMEM;
					end else if (in_byte == CH_BSL) begin
						phase_d = PH_ESC;
					end else begin
						cmd.bytes[0] = in_byte;
						cmd.bvalid   = 1'b1;
						space_d      = space_q - 16'd1;
					end
				end
				PH_ESC: begin
					phase_d = PH_IDLE;
					unique case (in_byte) inside
						CH_B: cmd.bytes[0] = 8'h08;
						CH_F: cmd.bytes[0] = 8'h0C;
						CH_N: cmd.bytes[0] = 8'h0A;
						CH_R: cmd.bytes[0] = 8'h0D;
						CH_T: cmd.bytes[0] = 8'h09;
						CH_QUOTE, CH_BSL, CH_SLASH: cmd.bytes[0] = in_byte;
						CH_U: begin
							phase_d = PH_UHEX;
							hex_d   = '0;
							bad_d   = 1'b0;
							dcnt_d  = '0;
						end
						CH_X: begin
							phase_d = PH_XHEX;
							hex_d   = '0;
							bad_d   = 1'b0;
							dcnt_d  = '0;
						end
						default: begin
							fail_en   = 1'b1;
							fail_code = ST_NOTIMPL;
						end
					endcase
					if (!fail_en && in_byte != CH_U && in_byte != CH_X) begin
						cmd.bvalid = 1'b1;
						space_d    = space_q - 16'd1;
					end
				end
				PH_XHEX: begin
					if (dig[4]) begin
						fail_en = 1'b1;
					end else if (dcnt_q == 2'd0) begin
						hex_d  = {8'h00, hex_q[3:0], dig[3:0]};
						dcnt_d = 2'd1;
					end else begin
						cmd.bytes[0] = {hex_q[3:0], dig[3:0]};
						cmd.bvalid   = 1'b1;
						space_d      = space_q - 16'd1;
						hex_d        = '0;
						bad_d        = 1'b0;
						dcnt_d       = '0;
						phase_d      = PH_IDLE;
					end
				end
				PH_UHEX, PH_LHEX: begin
					if (dcnt_q != 2'd3) begin
						bad_d  = u_bad;
						hex_d  = u_acc;
						dcnt_d = dcnt_q + 2'd1;
					end else begin
						hex_d  = '0;
						bad_d  = 1'b0;
						dcnt_d = '0;
						if (phase_q == PH_UHEX &&
							u_code >= 16'hDC00 && u_code <= 16'hDFFF) begin
							fail_en = 1'b1;
						end else if (phase_q == PH_UHEX &&
							u_code >= 16'hD800 && u_code <= 16'hDBFF) begin
							hs_d    = u_code[9:0];
							phase_d = PH_PAIR_BS;
						end else if (phase_q == PH_LHEX &&
							(u_code < 16'hDC00 || u_code > 16'hDFFF)) begin
							fail_en = 1'b1;
						end else if (space_q < 16'(enc_len)) begin
							fail_en = 1'b1;
						end else begin
							cmd.bytes    = enc_bytes;
							cmd.last_idx = 2'(enc_len - 3'd1);
							cmd.bvalid   = 1'b1;
							space_d      = space_q - 16'(enc_len);
							phase_d      = PH_IDLE;
						end
					end
				end
				PH_PAIR_BS: begin
					if (in_byte == CH_BSL) phase_d = PH_PAIR_U;
					else fail_en = 1'b1;
				end
				PH_PAIR_U: begin
					if (in_byte == CH_U) begin
						phase_d = PH_LHEX;
						hex_d   = '0;
						bad_d   = 1'b0;
						dcnt_d  = '0;
					end else begin
						fail_en = 1'b1;
					end
				end
				default: fail_en = 1'b1;
			endcase
		end

		if (fail_en) begin
			err_d      = fail_code;
			phase_d    = PH_IDLE;
			hex_d      = '0;
			bad_d      = 1'b0;
			dcnt_d     = '0;
			space_d    = space_q;
			cmd        = '0;
			cmd.status = fail_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q   <= '0;
			bad_q   <= 1'b0;
			dcnt_q  <= '0;
			hs_q    <= '0;
			space_q <= 16'hFFFF;
			err_q   <= ST_BUSY;
			cap_q   <= 16'hFFFF;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			if (q_push) begin
				phase_q <= phase_d;
				hex_q   <= hex_d;
				bad_q   <= bad_d;
				dcnt_q  <= dcnt_d;
				hs_q    <= hs_d;
				space_q <= space_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

[hdl/esu_queue.sv]
// Command queue between the parser and the result serializer.
module esu_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  esu_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output esu_pkg::cmd_t rd_cmd,
	output logic          empty
);
	import esu_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[hdl/esu_back.sv]
// Back end: splits each command into result transfers behind an output register.
module esu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  esu_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic [2:0]    status,
	output logic          run_last
);
	import esu_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	status_t    status_q;
	logic       run_last_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	assign load    = !q_empty && (!out_valid_q || out_ready);
	assign at_last = (idx_q == head.last_idx);
	assign q_pop   = load && at_last;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign status     = status_q;
	assign run_last   = run_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head.bytes[idx_q];
			byte_valid_q <= head.bvalid;
			status_q     <= head.status;
			run_last_q   <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/esu_checker.sv]
// Port-level checker for the escaped string unescaper, with its bind.
`include "assert_macros.svh"

module esu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic [2:0] status,
	input logic       run_last
);
	import esu_pkg::*;

	`AST_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "out_valid dropped")
	`AST_IMP(a_idle_zero, clk, arst_n, out_valid && !byte_valid, out_byte == 8'h00 && run_last, "empty result not single or nonzero")
	`AST_IMP(a_done_shape, clk, arst_n, out_valid && status == ST_DONE, byte_valid && run_last && out_byte == 8'h00, "bad done result")
	`AST_IMP(a_err_shape, clk, arst_n, out_valid && (status == ST_NOMEM || status == ST_FAULT || status == ST_NOTIMPL), !byte_valid, "error result carries a byte")
	`AST_IMP(a_status_range, clk, arst_n, out_valid, status <= ST_NOTIMPL, "status out of range")

endmodule

bind escaped_string_unescaper esu_checker u_esu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.byte_valid (byte_valid),
	.status     (status),
	.run_last   (run_last)
);
